// ----- rtl/sensor_compensation_trio_macros.svh -----
// Assertion helpers shared by the files that check this block.
`ifndef SENSOR_COMPENSATION_TRIO_MACROS_SVH
`define SENSOR_COMPENSATION_TRIO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCT_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sensor compensation check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sensor compensation check failed");

`endif

// ----- rtl/sct_pkg.sv -----
`default_nettype none

package sct_pkg;

    localparam int DATA_W    = 64;
    localparam int RAW_W     = 20;
    localparam int VAL_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int SH_W      = 6;
    localparam int PC_W      = 7;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [1:0] {
        MODE_TEMP  = 2'd0,
        MODE_PRESS = 2'd1,
        MODE_HUM   = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP     = 3'd0,
        CFG_PRESS_LO = 3'd1,
        CFG_PRESS_HI = 3'd2,
        CFG_EXTRA    = 3'd3,
        CFG_HUM      = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_ASR,
        OP_SHL,
        OP_MUL,
        OP_DIV,
        OP_SETTF,
        OP_BRZ,
        OP_OUT_SAT,
        OP_OUT_HUM,
        OP_OUT_FAULT,
        OP_OUT_ZERO
    } op_t;

    typedef enum logic [5:0] {
        SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4,
        SRC_RAW, SRC_ADC, SRC_TF,
        SRC_T1, SRC_T2, SRC_T3,
        SRC_P1, SRC_P2, SRC_P3, SRC_P4, SRC_P5, SRC_P6, SRC_P7, SRC_P8, SRC_P9,
        SRC_H1, SRC_H2, SRC_H3, SRC_H4, SRC_H5, SRC_H6,
        SRC_K5, SRC_K128, SRC_K128000, SRC_K1048576, SRC_K3125, SRC_K76800,
        SRC_K16384, SRC_K2097152, SRC_K8192, SRC_K32768, SRC_K2P47,
        SRC_ZERO
    } src_t;

    typedef struct packed {
        op_t             op;
        src_t            dst;
        src_t            a;
        src_t            b;
        logic [SH_W-1:0] sh;
    } ucmd_t;

    typedef struct packed {
        logic  load;
        logic  go;
        ucmd_t u;
    } dp_cmd_t;

    typedef struct packed {
        logic r0_zero;
        logic done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/sensor_compensation_trio.sv -----
// Integer compensation of temperature, pressure and humidity readings. Each
// input transfer carries one raw reading and its kind in s_tuser; the block
// answers with exactly one output transfer holding the fixed-point result
// (temperature in 0.01 degC, pressure in Pa Q24.8, humidity in %RH Q22.10,
// saturated to 32-bit signed) and a fault flag that is set only when the
// pressure divisor came out as zero. A temperature reading also updates the
// stored fine temperature used by later pressure and humidity readings, so
// send a temperature reading first. Coefficients are written through the
// configuration channel; the user must write them only while the block is
// idle, as the block does not enforce it. One reading is worked on at a time.
// The single shared 32x32 multiplier builds each 64-bit product from partial
// products, and the divider produces one quotient bit a cycle. A finished
// result waits in the output register, so the next reading is taken while it
// is pending.
`default_nettype none

`include "sensor_compensation_trio_macros.svh"

module sensor_compensation_trio (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write channel.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sct_pkg::DATA_W-1:0]    cfg_data,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [23:0]                   s_tdata,  // [19:0] raw_reading
    input  wire logic [1:0]                    s_tuser,  // [1:0] mode
    // Output stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,  // [31:0] compensated_value
    output logic [0:0]                         m_tuser   // [0] divide_fault
);
    import sct_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    logic     fault;

    // Registers can be written at any time; the user keeps writes to idle periods.
    assign cfg_ready = 1'b1;

    sct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .in_ready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    sct_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .raw_in    (s_tdata[RAW_W-1:0]),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .out_value (m_tdata),
        .out_fault (fault),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign m_tuser[0] = fault;

    // Once a reading is taken the block is busy in the cycle after.
    `SCT_ASSERT_NEXT(busy_after_accept, s_tvalid && s_tready, !s_tready)
    // A faulting pressure result always carries a zero value.
    `SCT_ASSERT_SAME(fault_forces_zero, m_tvalid && m_tuser[0], m_tdata == 32'h0)
    // The multiplier or divider only finishes while a reading is in work.
    `SCT_ASSERT_SAME(unit_done_while_busy, dp_stat.done, !s_tready)

endmodule

`default_nettype wire

// ----- rtl/sct_ctrl.sv -----
`default_nettype none

module sct_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic [1:0]     in_mode,
    output logic                in_ready,
    input  wire sct_pkg::dp_stat_t stat,
    output sct_pkg::dp_cmd_t    cmd
);
    import sct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_WAIT  = 3'b100
    } state_t;

    localparam pc_t PC_TEMP  = 7'd0;
    localparam pc_t PC_PRESS = 7'd17;
    localparam pc_t PC_FAULT = 7'd51;
    localparam pc_t PC_NONE  = 7'd52;
    localparam pc_t PC_HUM   = 7'd53;

    state_t state_reg, state_next;
    pc_t    pc_reg, pc_next;
    ucmd_t  cur;

    function automatic ucmd_t mk(op_t op, src_t d, src_t a, src_t b, logic [SH_W-1:0] sh);
        ucmd_t c;
        c.op  = op;
        c.dst = d;
        c.a   = a;
        c.b   = b;
        c.sh  = sh;
        return c;
    endfunction

    // Micro-program: one entry per datapath step.
    function automatic ucmd_t rom(pc_t pc);
        ucmd_t c;
        unique case (pc)
            // temperature
            7'd0:  c = mk(OP_ASR, SRC_R0, SRC_RAW, SRC_ZERO, 6'd3);
            7'd1:  c = mk(OP_SHL, SRC_R1, SRC_T1, SRC_ZERO, 6'd1);
            7'd2:  c = mk(OP_SUB, SRC_R0, SRC_R0, SRC_R1, 6'd0);
            7'd3:  c = mk(OP_MUL, SRC_R0, SRC_R0, SRC_T2, 6'd0);
            7'd4:  c = mk(OP_ASR, SRC_R0, SRC_R0, SRC_ZERO, 6'd11);
            7'd5:  c = mk(OP_ASR, SRC_R1, SRC_RAW, SRC_ZERO, 6'd4);
            7'd6:  c = mk(OP_SUB, SRC_R1, SRC_R1, SRC_T1, 6'd0);
            7'd7:  c = mk(OP_MUL, SRC_R1, SRC_R1, SRC_R1, 6'd0);
            7'd8:  c = mk(OP_ASR, SRC_R1, SRC_R1, SRC_ZERO, 6'd12);
            7'd9:  c = mk(OP_MUL, SRC_R1, SRC_R1, SRC_T3, 6'd0);
            7'd10: c = mk(OP_ASR, SRC_R1, SRC_R1, SRC_ZERO, 6'd14);
            7'd11: c = mk(OP_ADD, SRC_R0, SRC_R0, SRC_R1, 6'd0);
            7'd12: c = mk(OP_SETTF, SRC_R0, SRC_R0, SRC_ZERO, 6'd0);
            7'd13: c = mk(OP_MUL, SRC_R0, SRC_R0, SRC_K5, 6'd0);
            7'd14: c = mk(OP_ADD, SRC_R0, SRC_R0, SRC_K128, 6'd0);
            7'd15: c = mk(OP_ASR, SRC_R0, SRC_R0, SRC_ZERO, 6'd8);
            7'd16: c = mk(OP_OUT_SAT, SRC_R0, SRC_R0, SRC_ZERO, 6'd0);
            // pressure
            7'd17: c = mk(OP_SUB, SRC_R0, SRC_TF, SRC_K128000, 6'd0);
            7'd18: c = mk(OP_MUL, SRC_R1, SRC_R0, SRC_R0, 6'd0);
            7'd19: c = mk(OP_MUL, SRC_R2, SRC_R1, SRC_P6, 6'd0);
            7'd20: c = mk(OP_MUL, SRC_R3, SRC_R0, SRC_P5, 6'd0);
            7'd21: c = mk(OP_SHL, SRC_R3, SRC_R3, SRC_ZERO, 6'd17);
            7'd22: c = mk(OP_ADD, SRC_R2, SRC_R2, SRC_R3, 6'd0);
            7'd23: c = mk(OP_SHL, SRC_R3, SRC_P4, SRC_ZERO, 6'd35);
            7'd24: c = mk(OP_ADD, SRC_R2, SRC_R2, SRC_R3, 6'd0);
            7'd25: c = mk(OP_MUL, SRC_R3, SRC_R1, SRC_P3, 6'd0);
            7'd26: c = mk(OP_ASR, SRC_R3, SRC_R3, SRC_ZERO, 6'd8);
            7'd27: c = mk(OP_MUL, SRC_R4, SRC_R0, SRC_P2, 6'd0);
            7'd28: c = mk(OP_SHL, SRC_R4, SRC_R4, SRC_ZERO, 6'd12);
            7'd29: c = mk(OP_ADD, SRC_R0, SRC_R3, SRC_R4, 6'd0);
            7'd30: c = mk(OP_ADD, SRC_R0, SRC_R0, SRC_K2P47, 6'd0);
            7'd31: c = mk(OP_MUL, SRC_R0, SRC_R0, SRC_P1, 6'd0);
            7'd32: c = mk(OP_ASR, SRC_R0, SRC_R0, SRC_ZERO, 6'd33);
            7'd33: c = mk(OP_BRZ, SRC_R0, SRC_R0, SRC_ZERO, 6'd0);
            7'd34: c = mk(OP_SUB, SRC_R1, SRC_K1048576, SRC_RAW, 6'd0);
            7'd35: c = mk(OP_SHL, SRC_R1, SRC_R1, SRC_ZERO, 6'd31);
            7'd36: c = mk(OP_SUB, SRC_R1, SRC_R1, SRC_R2, 6'd0);
            7'd37: c = mk(OP_MUL, SRC_R1, SRC_R1, SRC_K3125, 6'd0);
            7'd38: c = mk(OP_DIV, SRC_R1, SRC_R1, SRC_R0, 6'd0);
            7'd39: c = mk(OP_ASR, SRC_R2, SRC_R1, SRC_ZERO, 6'd13);
            7'd40: c = mk(OP_MUL, SRC_R3, SRC_P9, SRC_R2, 6'd0);
            7'd41: c = mk(OP_MUL, SRC_R3, SRC_R3, SRC_R2, 6'd0);
            7'd42: c = mk(OP_ASR, SRC_R3, SRC_R3, SRC_ZERO, 6'd25);
            7'd43: c = mk(OP_MUL, SRC_R4, SRC_P8, SRC_R1, 6'd0);
            7'd44: c = mk(OP_ASR, SRC_R4, SRC_R4, SRC_ZERO, 6'd19);
            7'd45: c = mk(OP_ADD, SRC_R1, SRC_R1, SRC_R3, 6'd0);
            7'd46: c = mk(OP_ADD, SRC_R1, SRC_R1, SRC_R4, 6'd0);
            7'd47: c = mk(OP_ASR, SRC_R1, SRC_R1, SRC_ZERO, 6'd8);
            7'd48: c = mk(OP_SHL, SRC_R2, SRC_P7, SRC_ZERO, 6'd4);
            7'd49: c = mk(OP_ADD, SRC_R1, SRC_R1, SRC_R2, 6'd0);
            7'd50: c = mk(OP_OUT_SAT, SRC_R1, SRC_R1, SRC_ZERO, 6'd0);
            7'd51: c = mk(OP_OUT_FAULT, SRC_R0, SRC_ZERO, SRC_ZERO, 6'd0);
            7'd52: c = mk(OP_OUT_ZERO, SRC_R0, SRC_ZERO, SRC_ZERO, 6'd0);
            // humidity
            7'd53: c = mk(OP_SUB, SRC_R0, SRC_TF, SRC_K76800, 6'd0);
            7'd54: c = mk(OP_SHL, SRC_R1, SRC_ADC, SRC_ZERO, 6'd14);
            7'd55: c = mk(OP_SHL, SRC_R2, SRC_H4, SRC_ZERO, 6'd20);
            7'd56: c = mk(OP_SUB, SRC_R1, SRC_R1, SRC_R2, 6'd0);
            7'd57: c = mk(OP_MUL, SRC_R2, SRC_H5, SRC_R0, 6'd0);
            7'd58: c = mk(OP_SUB, SRC_R1, SRC_R1, SRC_R2, 6'd0);
            7'd59: c = mk(OP_ADD, SRC_R1, SRC_R1, SRC_K16384, 6'd0);
            7'd60: c = mk(OP_ASR, SRC_R1, SRC_R1, SRC_ZERO, 6'd15);
            7'd61: c = mk(OP_MUL, SRC_R2, SRC_R0, SRC_H6, 6'd0);
            7'd62: c = mk(OP_ASR, SRC_R2, SRC_R2, SRC_ZERO, 6'd10);
            7'd63: c = mk(OP_MUL, SRC_R3, SRC_R0, SRC_H3, 6'd0);
            7'd64: c = mk(OP_ASR, SRC_R3, SRC_R3, SRC_ZERO, 6'd11);
            7'd65: c = mk(OP_ADD, SRC_R3, SRC_R3, SRC_K32768, 6'd0);
            7'd66: c = mk(OP_MUL, SRC_R2, SRC_R2, SRC_R3, 6'd0);
            7'd67: c = mk(OP_ASR, SRC_R2, SRC_R2, SRC_ZERO, 6'd10);
            7'd68: c = mk(OP_ADD, SRC_R2, SRC_R2, SRC_K2097152, 6'd0);
            7'd69: c = mk(OP_MUL, SRC_R2, SRC_R2, SRC_H2, 6'd0);
            7'd70: c = mk(OP_ADD, SRC_R2, SRC_R2, SRC_K8192, 6'd0);
            7'd71: c = mk(OP_ASR, SRC_R2, SRC_R2, SRC_ZERO, 6'd14);
            7'd72: c = mk(OP_MUL, SRC_R1, SRC_R1, SRC_R2, 6'd0);
            7'd73: c = mk(OP_ASR, SRC_R2, SRC_R1, SRC_ZERO, 6'd15);
            7'd74: c = mk(OP_MUL, SRC_R2, SRC_R2, SRC_R2, 6'd0);
            7'd75: c = mk(OP_ASR, SRC_R2, SRC_R2, SRC_ZERO, 6'd7);
            7'd76: c = mk(OP_MUL, SRC_R2, SRC_R2, SRC_H1, 6'd0);
            7'd77: c = mk(OP_ASR, SRC_R2, SRC_R2, SRC_ZERO, 6'd4);
            7'd78: c = mk(OP_SUB, SRC_R1, SRC_R1, SRC_R2, 6'd0);
            7'd79: c = mk(OP_OUT_HUM, SRC_R1, SRC_R1, SRC_ZERO, 6'd0);
            default: c = mk(OP_OUT_ZERO, SRC_R0, SRC_ZERO, SRC_ZERO, 6'd0);
        endcase
        return c;
    endfunction

    assign cur      = rom(pc_reg);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cmd.load   = 1'b0;
        cmd.go     = 1'b0;
        cmd.u      = cur;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ISSUE;
                    unique case (mode_t'(in_mode))
                        MODE_TEMP:  pc_next = PC_TEMP;
                        MODE_PRESS: pc_next = PC_PRESS;
                        MODE_HUM:   pc_next = PC_HUM;
                        MODE_NONE:  pc_next = PC_NONE;
                        default:    pc_next = PC_NONE;
                    endcase
                end
            end
            S_ISSUE:
            begin
                unique case (cur.op)
                    OP_OUT_SAT, OP_OUT_HUM, OP_OUT_FAULT, OP_OUT_ZERO:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.go     = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    OP_BRZ:
                    begin
                        pc_next = stat.r0_zero ? PC_FAULT : pc_reg + 1'b1;
                    end
                    OP_MUL, OP_DIV:
                    begin
                        cmd.go     = 1'b1;
                        pc_next    = pc_reg + 1'b1;
                        state_next = S_WAIT;
                    end
                    default:
                    begin
                        cmd.go  = 1'b1;
                        pc_next = pc_reg + 1'b1;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (stat.done)
                begin
                    state_next = S_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= PC_TEMP;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sct_datapath.sv -----
`default_nettype none

module sct_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    input  wire logic [sct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sct_pkg::DATA_W-1:0]   cfg_data,
    input  wire logic [sct_pkg::RAW_W-1:0]    raw_in,
    input  wire sct_pkg::dp_cmd_t             cmd,
    output sct_pkg::dp_stat_t                 stat,
    output logic [sct_pkg::VAL_W-1:0]         out_value,
    output logic                              out_fault,
    output logic                              out_valid,
    input  wire logic                         out_ready
);
    import sct_pkg::*;

    localparam logic [DATA_W-1:0] HUM_MAX = 64'd419430400;

    // Configuration and persistent state.
    logic [47:0]       temp_reg;
    logic [63:0]       plo_reg, phi_reg, hum_reg;
    logic [23:0]       extra_reg;
    logic [31:0]       tf_reg;
    // Working registers.
    logic [DATA_W-1:0] r0_reg, r1_reg, r2_reg, r3_reg, r4_reg;
    logic [RAW_W-1:0]  raw_reg;
    // Multiplier.
    logic [DATA_W-1:0] ma_reg, mb_reg, pp_reg, acc_reg;
    logic [1:0]        mcnt_reg;
    logic              mul_busy_reg;
    // Divider.
    logic [DATA_W-1:0] quo_reg, rem_reg, dvs_reg;
    logic              dneg_reg;
    logic [6:0]        dcnt_reg;
    logic              div_busy_reg;
    src_t              dst_reg;
    // Output.
    logic [VAL_W-1:0]  out_value_reg;
    logic              out_fault_reg, out_valid_reg;

    logic [DATA_W-1:0] a_val, b_val, alu_val, mul_val, div_val, wr_data;
    logic [31:0]       mx, my;
    logic [DATA_W-1:0] mprod;
    logic [DATA_W:0]   rem_t;
    logic              dge;
    logic              mul_done, div_done, wr_en;
    src_t              wr_dst;
    logic [VAL_W-1:0]  sat_val, hum_val;

    function automatic logic [DATA_W-1:0] sx16(logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic [DATA_W-1:0] pick(src_t s);
        logic [DATA_W-1:0] v;
        unique case (s)
            SRC_R0:       v = r0_reg;
            SRC_R1:       v = r1_reg;
            SRC_R2:       v = r2_reg;
            SRC_R3:       v = r3_reg;
            SRC_R4:       v = r4_reg;
            SRC_RAW:      v = {44'd0, raw_reg};
            SRC_ADC:      v = {48'd0, raw_reg[15:0]};
            SRC_TF:       v = {{32{tf_reg[31]}}, tf_reg};
            SRC_T1:       v = {48'd0, temp_reg[15:0]};
            SRC_T2:       v = sx16(temp_reg[31:16]);
            SRC_T3:       v = sx16(temp_reg[47:32]);
            SRC_P1:       v = {48'd0, plo_reg[15:0]};
            SRC_P2:       v = sx16(plo_reg[31:16]);
            SRC_P3:       v = sx16(plo_reg[47:32]);
            SRC_P4:       v = sx16(plo_reg[63:48]);
            SRC_P5:       v = sx16(phi_reg[15:0]);
            SRC_P6:       v = sx16(phi_reg[31:16]);
            SRC_P7:       v = sx16(phi_reg[47:32]);
            SRC_P8:       v = sx16(phi_reg[63:48]);
            SRC_P9:       v = sx16(extra_reg[15:0]);
            SRC_H1:       v = {56'd0, hum_reg[7:0]};
            SRC_H2:       v = sx16(hum_reg[23:8]);
            SRC_H3:       v = {56'd0, hum_reg[31:24]};
            SRC_H4:       v = sx16(hum_reg[47:32]);
            SRC_H5:       v = sx16(hum_reg[63:48]);
            SRC_H6:       v = {{56{extra_reg[23]}}, extra_reg[23:16]};
            SRC_K5:       v = 64'd5;
            SRC_K128:     v = 64'd128;
            SRC_K128000:  v = 64'd128000;
            SRC_K1048576: v = 64'd1048576;
            SRC_K3125:    v = 64'd3125;
            SRC_K76800:   v = 64'd76800;
            SRC_K16384:   v = 64'd16384;
            SRC_K2097152: v = 64'd2097152;
            SRC_K8192:    v = 64'd8192;
            SRC_K32768:   v = 64'd32768;
            SRC_K2P47:    v = 64'h0000_8000_0000_0000;
            default:      v = '0;
        endcase
        return v;
    endfunction

    assign a_val = pick(cmd.u.a);
    assign b_val = pick(cmd.u.b);

    always_comb
    begin
        unique case (cmd.u.op)
            OP_ADD:  alu_val = a_val + b_val;
            OP_SUB:  alu_val = a_val - b_val;
            OP_ASR:  alu_val = $signed(a_val) >>> cmd.u.sh;
            OP_SHL:  alu_val = a_val << cmd.u.sh;
            default: alu_val = a_val;
        endcase
    end

    // Saturation of the final value to 32-bit signed.
    always_comb
    begin
        if (!a_val[63] && (a_val[62:31] != '0))
        begin
            sat_val = 32'h7FFF_FFFF;
        end
        else if (a_val[63] && (a_val[62:31] != '1))
        begin
            sat_val = 32'h8000_0000;
        end
        else
        begin
            sat_val = a_val[31:0];
        end
    end

    // Humidity is clamped to 0..100 %RH before dropping to Q22.10.
    always_comb
    begin
        if (a_val[63])
        begin
            hum_val = '0;
        end
        else if (a_val > HUM_MAX)
        begin
            hum_val = VAL_W'(HUM_MAX >> 12);
        end
        else
        begin
            hum_val = VAL_W'(a_val >> 12);
        end
    end

    // 64-bit product modulo 2^64 from three 32x32 partial products.
    always_comb
    begin
        unique case (mcnt_reg)
            2'd1:
            begin
                mx = ma_reg[31:0];
                my = mb_reg[63:32];
            end
            2'd2:
            begin
                mx = ma_reg[63:32];
                my = mb_reg[31:0];
            end
            default:
            begin
                mx = ma_reg[31:0];
                my = mb_reg[31:0];
            end
        endcase
    end

    assign mprod    = mx * my;
    assign mul_done = mul_busy_reg && (mcnt_reg == 2'd3);
    assign mul_val  = acc_reg + {pp_reg[31:0], 32'd0};

    // Restoring division, one quotient bit a cycle.
    assign rem_t    = {rem_reg, quo_reg[63]};
    assign dge      = rem_t >= {1'b0, dvs_reg};
    assign div_done = div_busy_reg && (dcnt_reg == '0);
    assign div_val  = dneg_reg ? (64'd0 - quo_reg) : quo_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_dst  = cmd.u.dst;
        wr_data = alu_val;
        if (mul_done)
        begin
            wr_en   = 1'b1;
            wr_dst  = dst_reg;
            wr_data = mul_val;
        end
        else if (div_done)
        begin
            wr_en   = 1'b1;
            wr_dst  = dst_reg;
            wr_data = div_val;
        end
        else if (cmd.go && ((cmd.u.op == OP_ADD) || (cmd.u.op == OP_SUB) ||
                            (cmd.u.op == OP_ASR) || (cmd.u.op == OP_SHL)))
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg <= raw_in;
        end
        if (wr_en)
        begin
            unique case (wr_dst)
                SRC_R0:  r0_reg <= wr_data;
                SRC_R1:  r1_reg <= wr_data;
                SRC_R2:  r2_reg <= wr_data;
                SRC_R3:  r3_reg <= wr_data;
                SRC_R4:  r4_reg <= wr_data;
                default: r0_reg <= r0_reg;
            endcase
        end
        if (cmd.go && (cmd.u.op == OP_MUL))
        begin
            ma_reg  <= a_val;
            mb_reg  <= b_val;
            dst_reg <= cmd.u.dst;
        end
        if (mul_busy_reg)
        begin
            pp_reg <= mprod;
            if (mcnt_reg == 2'd1)
            begin
                acc_reg <= pp_reg;
            end
            else if (mcnt_reg == 2'd2)
            begin
                acc_reg <= acc_reg + {pp_reg[31:0], 32'd0};
            end
        end
        if (cmd.go && (cmd.u.op == OP_DIV))
        begin
            quo_reg  <= a_val[63] ? (64'd0 - a_val) : a_val;
            dvs_reg  <= b_val[63] ? (64'd0 - b_val) : b_val;
            dneg_reg <= a_val[63] ^ b_val[63];
            rem_reg  <= '0;
            dst_reg  <= cmd.u.dst;
        end
        else if (div_busy_reg && (dcnt_reg != '0))
        begin
            rem_reg <= dge ? DATA_W'(rem_t - {1'b0, dvs_reg}) : rem_t[DATA_W-1:0];
            quo_reg <= {quo_reg[62:0], dge};
        end
        if (cmd.go)
        begin
            unique case (cmd.u.op)
                OP_OUT_SAT:
                begin
                    out_value_reg <= sat_val;
                    out_fault_reg <= 1'b0;
                end
                OP_OUT_HUM:
                begin
                    out_value_reg <= hum_val;
                    out_fault_reg <= 1'b0;
                end
                OP_OUT_FAULT:
                begin
                    out_value_reg <= '0;
                    out_fault_reg <= 1'b1;
                end
                OP_OUT_ZERO:
                begin
                    out_value_reg <= '0;
                    out_fault_reg <= 1'b0;
                end
                default:
                begin
                    out_value_reg <= out_value_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg      <= '0;
            plo_reg       <= '0;
            phi_reg       <= '0;
            extra_reg     <= '0;
            hum_reg       <= '0;
            tf_reg        <= '0;
            mul_busy_reg  <= 1'b0;
            mcnt_reg      <= '0;
            div_busy_reg  <= 1'b0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_TEMP:     temp_reg  <= cfg_data[47:0];
                    CFG_PRESS_LO: plo_reg   <= cfg_data;
                    CFG_PRESS_HI: phi_reg   <= cfg_data;
                    CFG_EXTRA:    extra_reg <= cfg_data[23:0];
                    CFG_HUM:      hum_reg   <= cfg_data;
                    default:      hum_reg   <= hum_reg;
                endcase
            end
            if (cmd.go && (cmd.u.op == OP_SETTF))
            begin
                tf_reg <= a_val[31:0];
            end
            if (cmd.go && (cmd.u.op == OP_MUL))
            begin
                mul_busy_reg <= 1'b1;
                mcnt_reg     <= '0;
            end
            else if (mul_busy_reg)
            begin
                mcnt_reg <= mcnt_reg + 1'b1;
                if (mul_done)
                begin
                    mul_busy_reg <= 1'b0;
                end
            end
            if (cmd.go && (cmd.u.op == OP_DIV))
            begin
                div_busy_reg <= 1'b1;
                dcnt_reg     <= 7'd64;
            end
            else if (div_done)
            begin
                div_busy_reg <= 1'b0;
            end
            else if (div_busy_reg)
            begin
                dcnt_reg <= dcnt_reg - 1'b1;
            end
            if (cmd.go && ((cmd.u.op == OP_OUT_SAT) || (cmd.u.op == OP_OUT_HUM) ||
                           (cmd.u.op == OP_OUT_FAULT) || (cmd.u.op == OP_OUT_ZERO)))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.r0_zero  = (r0_reg == '0);
    assign stat.done     = mul_done || div_done;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_value = out_value_reg;
    assign out_fault = out_fault_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- bench/sensor_compensation_trio_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the sensor compensation block. A directed table of
// readings exercises reset values, the zero pressure divisor, mode 3 and wide
// humidity readings; random readings then follow under several coefficient
// settings, including coefficient extremes. Every result transfer is compared
// against a bit-true predictor kept in this file.
module sensor_compensation_trio_tb;

    import sct_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;

    typedef struct {
        logic [31:0] value;
        logic        fault;
    } reading_result_t;

    // One row of the directed table. Rows with has_fixed set carry a result
    // that can be read straight from the formulas; the rest use the predictor.
    typedef struct {
        mode_t       mode;
        logic [19:0] raw;
        logic        has_fixed;
        logic [31:0] fixed_value;
        logic        fixed_fault;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    // Predictor copy of the calibration registers and fine temperature.
    logic [47:0] cal_temp;
    logic [63:0] cal_press_lo;
    logic [63:0] cal_press_hi;
    logic [23:0] cal_extra;
    logic [63:0] cal_hum;
    logic [31:0] fine_temp;

    reading_result_t pending_results[$];
    int              mismatches;
    int              received;
    bit              sending_done;
    bit              hold_off;
    longint          cycle_count;

    sensor_compensation_trio DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit: far beyond the slowest correct run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic longint sat_to_32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // Signed division truncating toward zero; min / -1 wraps.
    function automatic longint div_trunc(longint n, longint d);
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q  = un / ud;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    // Works out the result of one reading and updates the fine temperature.
    function automatic reading_result_t compensate(mode_t mode, logic [19:0] raw);
        reading_result_t r;
        longint tf;
        longint t1, t2, t3, v1, v2, d, p;
        longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint h1, h2, h3, h4, h5, h6, adc, v, a, b, c;
        r.value = '0;
        r.fault = 1'b0;
        tf = longint'(signed'(fine_temp));
        case (mode)
            MODE_TEMP:
            begin
                t1 = longint'(cal_temp[15:0]);
                t2 = longint'(signed'(cal_temp[31:16]));
                t3 = longint'(signed'(cal_temp[47:32]));
                v1 = (((longint'(raw >> 3)) - (t1 << 1)) * t2) >>> 11;
                d  = longint'(raw >> 4) - t1;
                v2 = (((d * d) >>> 12) * t3) >>> 14;
                tf = v1 + v2;
                fine_temp = tf[31:0];
                r.value = 32'(sat_to_32((tf * 5 + 128) >>> 8));
            end
            MODE_PRESS:
            begin
                p1 = longint'(cal_press_lo[15:0]);
                p2 = longint'(signed'(cal_press_lo[31:16]));
                p3 = longint'(signed'(cal_press_lo[47:32]));
                p4 = longint'(signed'(cal_press_lo[63:48]));
                p5 = longint'(signed'(cal_press_hi[15:0]));
                p6 = longint'(signed'(cal_press_hi[31:16]));
                p7 = longint'(signed'(cal_press_hi[47:32]));
                p8 = longint'(signed'(cal_press_hi[63:48]));
                p9 = longint'(signed'(cal_extra[15:0]));
                v1 = tf - 128000;
                v2 = v1 * v1 * p6;
                v2 = v2 + ((v1 * p5) << 17);
                v2 = v2 + (p4 << 35);
                v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
                v1 = (((64'sd1 << 47) + v1) * p1) >>> 33;
                if (v1 == 0)
                    r.fault = 1'b1;
                else
                begin
                    p  = 1048576 - longint'(raw);
                    p  = div_trunc(((p << 31) - v2) * 3125, v1);
                    v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
                    v2 = (p8 * p) >>> 19;
                    p  = ((p + v1 + v2) >>> 8) + (p7 << 4);
                    r.value = 32'(sat_to_32(p));
                end
            end
            MODE_HUM:
            begin
                h1  = longint'(cal_hum[7:0]);
                h2  = longint'(signed'(cal_hum[23:8]));
                h3  = longint'(cal_hum[31:24]);
                h4  = longint'(signed'(cal_hum[47:32]));
                h5  = longint'(signed'(cal_hum[63:48]));
                h6  = longint'(signed'(cal_extra[23:16]));
                adc = longint'(raw[15:0]);
                v   = tf - 76800;
                a   = ((adc << 14) - (h4 << 20) - h5 * v + 16384) >>> 15;
                b   = ((((v * h6) >>> 10) * (((v * h3) >>> 11) + 32768)) >>> 10)
                      + 2097152;
                c   = (b * h2 + 8192) >>> 14;
                v   = a * c;
                v   = v - (((((v >>> 15) * (v >>> 15)) >>> 7) * h1) >>> 4);
                if (v < 0)
                    v = 0;
                if (v > 419430400)
                    v = 419430400;
                r.value = 32'(v >> 12);
            end
            default:
            begin
                // Mode 3 gives zero and leaves the fine temperature alone.
            end
        endcase
        return r;
    endfunction

    // Writes one calibration register and mirrors it; callers write only while the block is idle.
    task automatic write_cal(cfg_idx_t idx, logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_TEMP:     cal_temp     = data[47:0];
            CFG_PRESS_LO: cal_press_lo = data;
            CFG_PRESS_HI: cal_press_hi = data;
            CFG_EXTRA:    cal_extra    = data[23:0];
            CFG_HUM:      cal_hum      = data;
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all_cal(logic [47:0] t, logic [63:0] pl, logic [63:0] ph,
                                 logic [23:0] x, logic [63:0] h);
        write_cal(CFG_TEMP, {16'd0, t});
        write_cal(CFG_PRESS_LO, pl);
        write_cal(CFG_PRESS_HI, ph);
        write_cal(CFG_EXTRA, {40'd0, x});
        write_cal(CFG_HUM, h);
    endtask

    // Sends one reading after a random gap; the expectation is queued at the
    // accepting edge so it is always ahead of its result.
    task automatic send_reading(mode_t mode, logic [19:0] raw, bit use_fixed,
                                logic [31:0] fixed_value, logic fixed_fault);
        int gap;
        reading_result_t r;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        repeat (gap) @(negedge clk);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'd0, raw};
        do
            @(posedge clk);
        while (!s_tready);
        r = compensate(mode, raw);
        if (use_fixed)
        begin
            r.value = fixed_value;
            r.fault = fixed_fault;
        end
        pending_results.push_back(r);
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Every result is in by now; let the block settle before writes.
        repeat (200) @(posedge clk);
    endtask

    // Random modes, mostly temperature, pressure and humidity, with some mode 3.
    task automatic random_readings(int count);
        int    k;
        mode_t m;
        logic [19:0] raw;
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: m = MODE_TEMP;
                3, 4, 5: m = MODE_PRESS;
                6, 7, 8: m = MODE_HUM;
                default: m = MODE_NONE;
            endcase
            raw = 20'(($urandom_range(0, 7) == 0) ? $urandom
                                                   : $urandom_range(200000, 600000));
            send_reading(m, raw, 1'b0, '0, 1'b0);
        end
    endtask

    // Realistic calibration, close to typical factory values.
    task automatic typical_cal;
        write_all_cal({16'hfc18, 16'h6770, 16'h6e5c},
                      {16'h1770, 16'h0d0c, 16'hd6d0, 16'h8f1a},
                      {16'hbff0, 16'h249e, 16'h0023, 16'h0000 + 16'hfff9},
                      {8'h1e, 16'h1770},
                      {16'h0032, 16'h0140, 8'h00, 16'h0167, 8'h4b});
    endtask

    table_row_t directed[] = '{
        // After reset every coefficient is zero: temperature gives zero.
        '{MODE_TEMP,  20'h00000, 1'b1, 32'd0, 1'b0},
        '{MODE_TEMP,  20'hFFFFF, 1'b1, 32'd0, 1'b0},
        // P1 zero means the pressure divisor is zero.
        '{MODE_PRESS, 20'h00000, 1'b1, 32'd0, 1'b1},
        '{MODE_PRESS, 20'hFFFFF, 1'b1, 32'd0, 1'b1},
        '{MODE_HUM,   20'hFFFFF, 1'b0, 32'd0, 1'b0},
        '{MODE_NONE,  20'hFFFFF, 1'b1, 32'd0, 1'b0},
        '{MODE_NONE,  20'h55555, 1'b1, 32'd0, 1'b0}
    };

    table_row_t directed_cal[] = '{
        // Pressure and humidity before any temperature under this calibration.
        '{MODE_PRESS, 20'h5A5A5, 1'b0, 32'd0, 1'b0},
        '{MODE_HUM,   20'h07000, 1'b0, 32'd0, 1'b0},
        '{MODE_TEMP,  20'h82000, 1'b0, 32'd0, 1'b0},
        '{MODE_PRESS, 20'h54000, 1'b0, 32'd0, 1'b0},
        '{MODE_PRESS, 20'h00000, 1'b0, 32'd0, 1'b0},
        '{MODE_PRESS, 20'hFFFFF, 1'b0, 32'd0, 1'b0},
        // Humidity uses only the low 16 bits of the reading.
        '{MODE_HUM,   20'hF6A00, 1'b0, 32'd0, 1'b0},
        '{MODE_HUM,   20'h0FFFF, 1'b0, 32'd0, 1'b0},
        '{MODE_HUM,   20'h00000, 1'b0, 32'd0, 1'b0},
        '{MODE_NONE,  20'hAAAAA, 1'b1, 32'd0, 1'b0},
        '{MODE_TEMP,  20'hFFFFF, 1'b0, 32'd0, 1'b0},
        '{MODE_TEMP,  20'h00000, 1'b0, 32'd0, 1'b0},
        '{MODE_HUM,   20'h08000, 1'b0, 32'd0, 1'b0}
    };

    // Stimulus sequence: directed rows, then random phases under several
    // calibration settings, including all-ones and saturating extremes.
    initial
    begin
        int k;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cal_temp     = '0;
        cal_press_lo = '0;
        cal_press_hi = '0;
        cal_extra    = '0;
        cal_hum      = '0;
        fine_temp    = '0;
        sending_done = 1'b0;
        rst_n        = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_reading(directed[i].mode, directed[i].raw, directed[i].has_fixed,
                         directed[i].fixed_value, directed[i].fixed_fault);
        drain();
        // Fine temperature is still zero here, as all temperatures gave zero.
        typical_cal();
        foreach (directed_cal[i])
            send_reading(directed_cal[i].mode, directed_cal[i].raw,
                         directed_cal[i].has_fixed, directed_cal[i].fixed_value,
                         directed_cal[i].fixed_fault);

        random_readings(150);
        drain();
        // All ones: every signed coefficient is -1, unsigned ones at maximum.
        write_all_cal('1, '1, '1, '1, '1);
        random_readings(50);
        drain();
        // Signed coefficients at their extremes, driving results into saturation.
        write_all_cal({16'h7fff, 16'h7fff, 16'hffff},
                      {16'h7fff, 16'h7fff, 16'h8000, 16'hffff},
                      {16'h7fff, 16'h8000, 16'h7fff, 16'h8000},
                      {8'h7f, 16'h8000},
                      {16'h8000, 16'h7fff, 8'hff, 16'h7fff, 8'hff});
        random_readings(50);
        drain();
        for (k = 0; k < 3; k++)
        begin
            write_all_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                          {$urandom, $urandom}, 24'($urandom),
                          {$urandom, $urandom});
            random_readings(50);
            drain();
        end
        typical_cal();
        random_readings(50);
        sending_done = 1'b1;
    end

    // Result side: a random wait before each result, with one long hold-off
    // so the block backs up while readings keep being offered.
    initial
    begin
        int wait_cycles;
        m_tready = 1'b0;
        hold_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_off && received >= 40)
            begin
                hold_off = 1'b1;
                m_tready <= 1'b0;
                repeat (3000) @(negedge clk);
            end
            wait_cycles = $urandom_range(0, 15);
            if (wait_cycles != 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    // Result checker.
    initial
    begin
        reading_result_t e;
        mismatches = 0;
        received   = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                received++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: value %0d fault %0b",
                                 $signed(m_tdata), m_tuser[0]);
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (m_tdata !== e.value || m_tuser[0] !== e.fault)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %0d/%0b, got %0d/%0b",
                                     received, $signed(e.value), e.fault,
                                     $signed(m_tdata), m_tuser[0]);
                    end
                end
            end
        end
    end

    // End of run: all readings accepted, all results in, then a quiet spell.
    initial
    begin
        wait (sending_done);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
